// ===== hdl/delta_list_timer_queue_top_macros.svh =====
// Assertion macros for the delta list timer queue checker
`ifndef DELTA_LIST_TIMER_QUEUE_TOP_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_TOP_MACROS_SVH

// check in the same cycle
`define DLTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check in the following cycle
`define DLTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dltq_pkg.sv =====
// Shared types and constants of the delta list timer queue
`timescale 1ns / 1ps

package dltq_pkg;

  localparam int NUM_TIMERS_DEF  = 16;
  localparam int DELAY_WIDTH_DEF = 16;

  localparam int ID_W       = 4;
  localparam int MODE_W     = 2;
  localparam int DELAY_IN_W = 16;
  localparam int STATUS_W   = 2;
  localparam int MAX_OUT    = 16;
  localparam int OUT_CNT_W  = 4;

  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_START_ACTIVE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CANCEL_IDLE  = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic [2:0] {
    WAVE_NONE,
    WAVE_DEC,
    WAVE_INS,
    WAVE_SHIFT,
    WAVE_SRCH,
    WAVE_PULL
  } wave_op_t;

  typedef struct packed {
    wave_op_t        op;
    logic [ID_W-1:0] slot;
  } wave_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] slot;
  } entry_t;

endpackage

// ===== hdl/delta_list_timer_queue_top.sv =====
// Top level of the delta list timer queue: controller and a row of queue cells
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | req_valid, req_stall | mode, timer_id, delay_ticks
//  result   | res_valid, res_stall | kind, status, expired_id, last
//
//  Start and cancel pass through S_GAP, a refused one does not; the insert or remove
//  wave then runs down the cell row one cell per cycle, two cells ahead of the next.
//  A tick passes S_DEC_WAIT and S_CHECK when nothing is due; each expiring timer but
//  the last adds S_PULL_WAIT1 and S_PULL_WAIT2, the last S_GAP, set by the removal
//  wave that must pass the second cell before the next head check.
//  Reset clears every cell; a stalled result holds and blocks requests.
`timescale 1ns / 1ps

module delta_list_timer_queue_top #(
  parameter int NUM_TIMERS  = dltq_pkg::NUM_TIMERS_DEF,
  parameter int DELAY_WIDTH = dltq_pkg::DELAY_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [dltq_pkg::MODE_W-1:0]       mode,
  input  logic [dltq_pkg::ID_W-1:0]         timer_id,
  input  logic [dltq_pkg::DELAY_IN_W-1:0]   delay_ticks,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic                              kind,
  output logic [dltq_pkg::STATUS_W-1:0]     status,
  output logic [dltq_pkg::ID_W-1:0]         expired_id,
  output logic                              last
);
  import dltq_pkg::*;

  wave_t                  chain       [NUM_TIMERS];
  logic [DELAY_WIDTH-1:0] chain_delta [NUM_TIMERS];
  entry_t                 view        [NUM_TIMERS];
  logic [DELAY_WIDTH-1:0] view_delta  [NUM_TIMERS];

  dltq_ctrl #(
    .NUM_TIMERS  (NUM_TIMERS),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .timer_id     (timer_id),
    .delay_ticks  (delay_ticks),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .status       (status),
    .expired_id   (expired_id),
    .last         (last),
    .head         (view[0]),
    .head_delta   (view_delta[0]),
    .second       (view[1]),
    .second_delta (view_delta[1]),
    .carry        (chain[0]),
    .carry_delta  (chain_delta[0])
  );

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    if (g < NUM_TIMERS - 1) begin : g_mid
      dltq_cell #(
        .DELAY_WIDTH (DELAY_WIDTH)
      ) u_cell (
        .clk             (clk),
        .rst             (rst),
        .carry_in        (chain[g]),
        .carry_delta_in  (chain_delta[g]),
        .right           (view[g+1]),
        .right_delta     (view_delta[g+1]),
        .carry_out       (chain[g+1]),
        .carry_delta_out (chain_delta[g+1]),
        .view            (view[g]),
        .view_delta      (view_delta[g])
      );
    end else begin : g_tail
      dltq_cell #(
        .DELAY_WIDTH (DELAY_WIDTH)
      ) u_cell (
        .clk             (clk),
        .rst             (rst),
        .carry_in        (chain[g]),
        .carry_delta_in  (chain_delta[g]),
        .right           ('0),
        .right_delta     ('0),
        .carry_out       (),
        .carry_delta_out (),
        .view            (view[g]),
        .view_delta      (view_delta[g])
      );
    end
  end

endmodule

// ===== hdl/dltq_cell.sv =====
// One queue position: holds an entry and passes waves to its right neighbor
`timescale 1ns / 1ps

module dltq_cell #(
  parameter int DELAY_WIDTH = dltq_pkg::DELAY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dltq_pkg::wave_t        carry_in,
  input  logic [DELAY_WIDTH-1:0] carry_delta_in,
  input  dltq_pkg::entry_t       right,
  input  logic [DELAY_WIDTH-1:0] right_delta,
  output dltq_pkg::wave_t        carry_out,
  output logic [DELAY_WIDTH-1:0] carry_delta_out,
  output dltq_pkg::entry_t       view,
  output logic [DELAY_WIDTH-1:0] view_delta
);
  import dltq_pkg::*;

  logic                   valid, valid_next;
  logic [ID_W-1:0]        slot, slot_next;
  logic [DELAY_WIDTH-1:0] delta, delta_next;
  wave_op_t               carry_op, carry_op_next;
  logic [ID_W-1:0]        carry_slot, carry_slot_next;
  logic [DELAY_WIDTH-1:0] carry_delta, carry_delta_next;

  always_comb begin
    valid_next       = valid;
    slot_next        = slot;
    delta_next       = delta;
    carry_op_next    = WAVE_NONE;
    carry_slot_next  = '0;
    carry_delta_next = '0;
    unique case (carry_in.op)
      WAVE_NONE: begin
      end
      WAVE_DEC: begin
        if (valid && delta != '0) begin
          delta_next = delta - 1'b1;
        end
      end
      WAVE_INS: begin
        if (!valid) begin
          valid_next = 1'b1;
          slot_next  = carry_in.slot;
          delta_next = carry_delta_in;
        end else if (carry_delta_in < delta) begin
          slot_next        = carry_in.slot;
          delta_next       = carry_delta_in;
          carry_op_next    = WAVE_SHIFT;
          carry_slot_next  = slot;
          carry_delta_next = delta - carry_delta_in;
        end else begin
          carry_op_next    = WAVE_INS;
          carry_slot_next  = carry_in.slot;
          carry_delta_next = carry_delta_in - delta;
        end
      end
      WAVE_SHIFT: begin
        valid_next = 1'b1;
        slot_next  = carry_in.slot;
        delta_next = carry_delta_in;
        if (valid) begin
          carry_op_next    = WAVE_SHIFT;
          carry_slot_next  = slot;
          carry_delta_next = delta;
        end
      end
      WAVE_SRCH: begin
        if (valid && slot == carry_in.slot) begin
          if (right.valid) begin
            slot_next     = right.slot;
            delta_next    = delta + right_delta;
            carry_op_next = WAVE_PULL;
          end else begin
            valid_next = 1'b0;
          end
        end else if (valid) begin
          carry_op_next   = WAVE_SRCH;
          carry_slot_next = carry_in.slot;
        end
      end
      WAVE_PULL: begin
        if (right.valid) begin
          slot_next     = right.slot;
          delta_next    = right_delta;
          carry_op_next = WAVE_PULL;
        end else begin
          valid_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      carry_op <= WAVE_NONE;
    end else begin
      valid    <= valid_next;
      carry_op <= carry_op_next;
    end
    slot        <= slot_next;
    delta       <= delta_next;
    carry_slot  <= carry_slot_next;
    carry_delta <= carry_delta_next;
  end

  assign carry_out       = '{op: carry_op, slot: carry_slot};
  assign carry_delta_out = carry_delta;
  assign view            = '{valid: valid, slot: slot};
  assign view_delta      = delta;

endmodule

// ===== hdl/dltq_ctrl.sv =====
// Request decode, slot bookkeeping, expiry sequencing and result register
`timescale 1ns / 1ps

module dltq_ctrl #(
  parameter int NUM_TIMERS  = dltq_pkg::NUM_TIMERS_DEF,
  parameter int DELAY_WIDTH = dltq_pkg::DELAY_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [dltq_pkg::MODE_W-1:0]       mode,
  input  logic [dltq_pkg::ID_W-1:0]         timer_id,
  input  logic [dltq_pkg::DELAY_IN_W-1:0]   delay_ticks,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic                              kind,
  output logic [dltq_pkg::STATUS_W-1:0]     status,
  output logic [dltq_pkg::ID_W-1:0]         expired_id,
  output logic                              last,
  input  dltq_pkg::entry_t                  head,
  input  logic [DELAY_WIDTH-1:0]            head_delta,
  input  dltq_pkg::entry_t                  second,
  input  logic [DELAY_WIDTH-1:0]            second_delta,
  output dltq_pkg::wave_t                   carry,
  output logic [DELAY_WIDTH-1:0]            carry_delta
);
  import dltq_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int DEXT  = (DELAY_WIDTH > DELAY_IN_W) ? DELAY_WIDTH : DELAY_IN_W;
  localparam logic [DEXT-1:0] DMAX = DEXT'({DELAY_WIDTH{1'b1}});

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_DEC_WAIT,
    S_PULL_WAIT1,
    S_PULL_WAIT2,
    S_CHECK
  } state_t;

  state_t                 state;
  logic [NUM_TIMERS-1:0]  active;
  logic [CNT_W-1:0]       count;
  logic [OUT_CNT_W-1:0]   n_out;
  wave_op_t               carry_op, carry_op_next;
  logic [ID_W-1:0]        carry_slot;

  logic                   out_free;
  logic                   id_ok;
  logic [IDX_W-1:0]       id_idx;
  logic [IDX_W-1:0]       head_idx;
  logic                   active_hit;
  logic                   full;
  logic                   start_ok;
  logic [DEXT-1:0]        delay_ext;
  logic [DELAY_WIDTH-1:0] delay_sat;
  logic                   expiring;
  logic                   final_expiry;
  logic                   accept;
  logic                   emit;
  logic                   res_load;

  assign out_free     = !res_valid || !res_stall;
  assign req_stall    = !(state == S_IDLE && out_free);
  assign id_ok        = {28'd0, timer_id} < 32'(NUM_TIMERS);
  assign id_idx       = IDX_W'(timer_id);
  assign head_idx     = IDX_W'(head.slot);
  assign active_hit   = id_ok && active[id_idx];
  assign full         = count >= CNT_W'(NUM_TIMERS);
  assign start_ok     = id_ok && !active_hit && !full;
  assign delay_ext    = DEXT'(delay_ticks);
  assign delay_sat    = DELAY_WIDTH'((delay_ext > DMAX) ? DMAX : delay_ext);
  assign expiring     = head.valid && head_delta == '0;
  assign final_expiry = (n_out == OUT_CNT_W'(MAX_OUT - 1)) ||
                        !(second.valid && second_delta == '0);
  assign accept       = state == S_IDLE && req_valid && out_free;
  assign emit         = state == S_CHECK && expiring && out_free;
  assign res_load     = emit || (accept && (mode == MODE_START || mode == MODE_CANCEL));

  assign carry = '{op: carry_op, slot: carry_slot};

  always_comb begin
    carry_op_next = WAVE_NONE;
    if (emit) begin
      carry_op_next = WAVE_PULL;
    end else if (accept) begin
      unique case (mode)
        MODE_TICK:   carry_op_next = WAVE_DEC;
        MODE_START:  carry_op_next = start_ok ? WAVE_INS : WAVE_NONE;
        MODE_CANCEL: carry_op_next = active_hit ? WAVE_SRCH : WAVE_NONE;
        default:     carry_op_next = WAVE_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      active    <= '0;
      count     <= '0;
      n_out     <= '0;
      carry_op  <= WAVE_NONE;
    end else begin
      carry_op <= carry_op_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (mode)
              MODE_TICK: begin
                n_out <= '0;
                state <= S_DEC_WAIT;
              end
              MODE_START: begin
                kind       <= KIND_STATUS;
                expired_id <= '0;
                last       <= 1'b1;
                if (start_ok) begin
                  status         <= ST_OK;
                  carry_slot     <= timer_id;
                  carry_delta    <= delay_sat;
                  active[id_idx] <= 1'b1;
                  count          <= count + 1'b1;
                  state          <= S_GAP;
                end else begin
                  status <= ST_START_ACTIVE;
                end
              end
              MODE_CANCEL: begin
                kind       <= KIND_STATUS;
                expired_id <= '0;
                last       <= 1'b1;
                if (active_hit) begin
                  status         <= ST_OK;
                  carry_slot     <= timer_id;
                  carry_delta    <= '0;
                  active[id_idx] <= 1'b0;
                  count          <= count - 1'b1;
                  state          <= S_GAP;
                end else begin
                  status <= ST_CANCEL_IDLE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_GAP: begin
          state <= S_IDLE;
        end
        S_DEC_WAIT: begin
          state <= S_CHECK;
        end
        S_PULL_WAIT1: begin
          state <= S_PULL_WAIT2;
        end
        S_PULL_WAIT2: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!expiring) begin
            state <= S_IDLE;
          end else if (out_free) begin
            kind             <= KIND_EXPIRY;
            status           <= ST_OK;
            expired_id       <= head.slot;
            last             <= final_expiry;
            carry_slot       <= '0;
            carry_delta      <= '0;
            active[head_idx] <= 1'b0;
            count            <= count - 1'b1;
            n_out            <= n_out + 1'b1;
            state            <= final_expiry ? S_GAP : S_PULL_WAIT1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/dltq_checker.sv =====
// Port-level checker of the delta list timer queue and its bind
`timescale 1ns / 1ps
`include "delta_list_timer_queue_top_macros.svh"

module dltq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_stall,
  input logic [dltq_pkg::MODE_W-1:0]       mode,
  input logic                              res_valid,
  input logic                              res_stall,
  input logic                              kind,
  input logic [dltq_pkg::STATUS_W-1:0]     status,
  input logic [dltq_pkg::ID_W-1:0]         expired_id,
  input logic                              last
);
  import dltq_pkg::*;

  logic                       start_or_cancel;
  logic [STATUS_W+ID_W+1:0]   res_word;

  assign start_or_cancel = req_valid && !req_stall &&
                           (mode == MODE_START || mode == MODE_CANCEL);
  assign res_word        = {kind, status, expired_id, last};

  `DLTQ_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word), "stalled result changed")

  `DLTQ_ASSERT_NOW(a_status_single, res_valid && kind == KIND_STATUS, last && expired_id == '0, "bad status result")

  `DLTQ_ASSERT_NOW(a_expiry_clean, res_valid && kind == KIND_EXPIRY, status == ST_OK, "expiry report carries a status")

  `DLTQ_ASSERT_NEXT(a_status_follows, start_or_cancel, res_valid && kind == KIND_STATUS, "start or cancel gave no status")

endmodule

bind delta_list_timer_queue_top dltq_checker u_dltq_checker (.*);
